// ===== design/lcs_pkg.sv =====
// Shared types and constants for the LCS length engine.
package lcs_pkg;

  localparam int DEF_MAX_LEN = 1024;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 11;

  typedef enum logic [1:0] {
    SW_IDLE = 2'b01,
    SW_RUN  = 2'b10
  } sweep_state_t;

  typedef struct packed {
    logic              go;
    logic              first_pass;
    logic [CHAR_W-1:0] ch;
  } sweep_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

endpackage

// ===== design/lcs_row_sweep.sv =====
// Character store, DP row memory and the row sweep datapath.
module lcs_row_sweep #(
  parameter int  MAX_LEN = lcs_pkg::DEF_MAX_LEN,
  localparam int IDX_W   = $clog2(MAX_LEN),
  localparam int CNT_W   = $clog2(MAX_LEN + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lcs_pkg::sweep_ctl_t       ctl,
  input  logic [CNT_W-1:0]          first_len,
  input  logic                      store_we,
  input  logic [IDX_W-1:0]          store_addr,
  input  logic [lcs_pkg::CHAR_W-1:0] store_data,
  output lcs_pkg::sweep_stat_t      stat,
  output logic [CNT_W-1:0]          final_val
);

  logic [lcs_pkg::CHAR_W-1:0] char_mem [MAX_LEN];
  logic [CNT_W-1:0]           row_mem  [MAX_LEN];

  lcs_pkg::sweep_state_t      state;
  logic [CNT_W-1:0]           rd_cnt;
  logic [CNT_W-1:0]           p_idx;
  logic                       p_valid;
  logic                       first_pass;
  logic [lcs_pkg::CHAR_W-1:0] cur_ch;
  logic [lcs_pkg::CHAR_W-1:0] ch_q;
  logic [CNT_W-1:0]           row_q;
  logic [CNT_W-1:0]           diag;
  logic [CNT_W-1:0]           above;

  logic                       issue;
  logic [IDX_W-1:0]           rd_addr;
  logic [CNT_W-1:0]           left;
  logic [CNT_W-1:0]           cell_next;
  logic                       last_cell;

  assign issue   = (state == lcs_pkg::SW_RUN) && (rd_cnt != first_len);
  assign rd_addr = rd_cnt[IDX_W-1:0];

  // first sweep of a pair sees an all-zero row; the value read is ignored
  assign left      = first_pass ? '0 : row_q;
  assign cell_next = (ch_q == cur_ch) ? diag + CNT_W'(1)
                                      : ((above > left) ? above : left);
  assign last_cell = p_valid && (p_idx == first_len - CNT_W'(1));

  assign stat.busy = (state != lcs_pkg::SW_IDLE);
  assign stat.done = last_cell;
  assign final_val = cell_next;

  always_ff @(posedge clk) begin
    if (store_we) begin
      char_mem[store_addr] <= store_data;
    end
    ch_q <= char_mem[rd_addr];
  end

  // write-back trails the read by one entry, so the two never meet
  always_ff @(posedge clk) begin
    if (p_valid) begin
      row_mem[p_idx[IDX_W-1:0]] <= cell_next;
    end
    row_q <= row_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lcs_pkg::SW_IDLE;
      p_valid <= 1'b0;
    end else begin
      p_valid <= issue;
      unique case (state)
        lcs_pkg::SW_IDLE: begin
          if (ctl.go) state <= lcs_pkg::SW_RUN;
        end
        lcs_pkg::SW_RUN: begin
          if (last_cell) state <= lcs_pkg::SW_IDLE;
        end
        default: state <= lcs_pkg::SW_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= rd_cnt;
    if (ctl.go) begin
      rd_cnt     <= '0;
      first_pass <= ctl.first_pass;
      cur_ch     <= ctl.ch;
      diag       <= '0;
      above      <= '0;
    end else begin
      if (issue) rd_cnt <= rd_cnt + CNT_W'(1);
      if (p_valid) begin
        diag  <= left;
        above <= cell_next;
      end
    end
  end

  a_go_when_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.go |-> state == lcs_pkg::SW_IDLE)
    else $error("sweep started while running");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> state == lcs_pkg::SW_IDLE)
    else $error("sweep did not stop after last cell");

  a_wb_in_range: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> p_idx < first_len)
    else $error("row write beyond first string");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (p_valid && issue) |-> rd_addr != p_idx[IDX_W-1:0])
    else $error("row read and write hit the same entry");

endmodule

// ===== design/lcs_length_engine_unit.sv =====
// Top level of the LCS length engine: command port, pair counters, result word.
//
// Usage: present string_select, char_code and last_char with start high; the
// word is taken at a rising edge where start is high and busy is low.
// First-string words (string_select = 0) are stored and never raise busy.
// Each second-string word sweeps the stored DP row, one entry per cycle
// through a registered-read row memory: busy stays high until the sweep has
// written its last cell, and no new word is taken while busy is high. A
// second-string word with an empty first string, or beyond MAX_LEN, does not
// sweep and does not raise busy.
// The result word (lcs_length, overflowed) appears with done for exactly one
// cycle after the word marked last_char: registered from the sweep's last cell
// when it sweeps, else in the cycle after its accepting edge. The receiver
// cannot stall; done is never high while busy is high.
// After each result the pair counters and overflow flag clear; the row memory
// needs no clearing pass because the first sweep of a pair reads it as zero.
// Reset (rst, synchronous) returns the block to idle with an empty pair.
module lcs_length_engine_unit #(
  parameter int MAX_LEN = lcs_pkg::DEF_MAX_LEN
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        string_select,
  input  logic [lcs_pkg::CHAR_W-1:0]  char_code,
  input  logic                        last_char,
  output logic                        done,
  output logic [lcs_pkg::LEN_W-1:0]   lcs_length,
  output logic                        overflowed
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0]      first_length;
  logic [CNT_W-1:0]      second_count;
  logic                  overflow_flag;
  logic [CNT_W-1:0]      final_len;
  logic                  pend_last;

  lcs_pkg::sweep_ctl_t   sweep_ctl;
  lcs_pkg::sweep_stat_t  sweep_stat;
  logic [CNT_W-1:0]      final_val;

  logic accept;
  logic is_first;
  logic is_second;
  logic first_room;
  logic second_room;
  logic store_we;
  logic do_sweep;
  logic direct_emit;
  logic sweep_emit;

  assign busy        = sweep_stat.busy;
  assign accept      = start && !busy;
  assign is_first    = accept && !string_select;
  assign is_second   = accept && string_select;
  assign first_room  = (first_length != CNT_W'(MAX_LEN));
  assign second_room = (second_count != CNT_W'(MAX_LEN));
  assign store_we    = is_first && (second_count == '0) && first_room;
  assign do_sweep    = is_second && second_room && (first_length != '0);
  assign direct_emit = is_second && last_char && !do_sweep;
  assign sweep_emit  = sweep_stat.done && pend_last;

  assign sweep_ctl.go         = do_sweep;
  assign sweep_ctl.first_pass = (second_count == '0);
  assign sweep_ctl.ch         = char_code;

  lcs_row_sweep #(
    .MAX_LEN (MAX_LEN)
  ) u_sweep (
    .clk        (clk),
    .rst        (rst),
    .ctl        (sweep_ctl),
    .first_len  (first_length),
    .store_we   (store_we),
    .store_addr (first_length[IDX_W-1:0]),
    .store_data (char_code),
    .stat       (sweep_stat),
    .final_val  (final_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= 1'b0;
      first_length  <= '0;
      second_count  <= '0;
      overflow_flag <= 1'b0;
      final_len     <= '0;
      pend_last     <= 1'b0;
    end else begin
      done <= direct_emit || sweep_emit;
      if (do_sweep) pend_last <= last_char;
      priority if (direct_emit || sweep_emit) begin
        first_length  <= '0;
        second_count  <= '0;
        overflow_flag <= 1'b0;
        final_len     <= '0;
      end else begin
        if (sweep_stat.done) final_len <= final_val;
        if (store_we) first_length <= first_length + CNT_W'(1);
        if (is_first && (second_count == '0) && !first_room) overflow_flag <= 1'b1;
        if (is_second && second_room) second_count <= second_count + CNT_W'(1);
        if (is_second && !second_room) overflow_flag <= 1'b1;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (sweep_emit) begin
      lcs_length <= lcs_pkg::LEN_W'(final_val);
      overflowed <= overflow_flag;
    end else if (direct_emit) begin
      lcs_length <= lcs_pkg::LEN_W'(final_len);
      overflowed <= overflow_flag || !second_room;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while sweep running");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    first_length <= CNT_W'(MAX_LEN))
    else $error("first string length beyond capacity");

  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    sweep_ctl.go |=> busy)
    else $error("sweep start did not raise busy");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the LCS length engine: string-pair words checked against a DP row predictor.
module tb_top;

  localparam int   MAX_LEN    = lcs_pkg::DEF_MAX_LEN;
  localparam int   CHAR_W     = lcs_pkg::CHAR_W;
  localparam int   LEN_W      = lcs_pkg::LEN_W;
  localparam int   IDLE_LIMIT = 4 * (MAX_LEN + 32);
  localparam int   TAIL_WORDS = 40;
  localparam int   STIM_WORDS = 580;
  localparam int   MIN_PAIRS  = 16;
  localparam logic SEL_FIRST  = 1'b0;
  localparam logic SEL_SECOND = 1'b1;

  typedef struct {
    logic              sel;
    logic [CHAR_W-1:0] ch;
    logic              last;
    int                gap;
    bit                drain;
  } cmd_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ovf;
  } lcs_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              string_select;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  logic              done;
  logic [LEN_W-1:0]  lcs_length;
  logic              overflowed;

  cmd_word_t   pending_words[$];
  lcs_result_t expected_results[$];

  // predictor state for the current pair
  logic [CHAR_W-1:0] first_chars [MAX_LEN];
  logic [LEN_W-1:0]  lcs_row [MAX_LEN];
  logic [LEN_W-1:0]  first_len;
  logic [LEN_W-1:0]  second_cnt;
  logic              drop_seen;

  int                mismatches;
  int                idle_cycles;
  int                idle_left;
  int                stim_words;
  int                pairs;
  logic              taken;
  bit                gaps_on;
  bit                wide_chars;
  logic [CHAR_W-1:0] alphabet [4];

  lcs_length_engine_unit #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .string_select (string_select),
    .char_code     (char_code),
    .last_char     (last_char),
    .done          (done),
    .lcs_length    (lcs_length),
    .overflowed    (overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_pair_state();
    for (int i = 0; i < MAX_LEN; i++) lcs_row[i] = '0;
    first_len  = '0;
    second_cnt = '0;
    drop_seen  = 1'b0;
  endfunction

  function automatic void sweep_row(input logic [CHAR_W-1:0] ch);
    logic [LEN_W-1:0] diag;
    logic [LEN_W-1:0] above;
    logic [LEN_W-1:0] left;
    logic [LEN_W-1:0] nxt;
    diag  = '0;
    above = '0;
    for (int i = 0; i < first_len; i++) begin
      left = lcs_row[i];
      if (first_chars[i] == ch) nxt = diag + 1'b1;
      else nxt = (above > left) ? above : left;
      diag       = left;
      lcs_row[i] = nxt;
      above      = nxt;
    end
  endfunction

  function automatic void track_word(input logic sel, input logic [CHAR_W-1:0] ch,
                                     input logic last);
    lcs_result_t res;
    if (sel == SEL_FIRST) begin
      // first-string words after the second string has begun are dropped silently
      if (second_cnt == 0) begin
        if (first_len < MAX_LEN) begin
          first_chars[first_len] = ch;
          first_len = first_len + 1'b1;
        end else begin
          drop_seen = 1'b1;
        end
      end
    end else begin
      if (second_cnt < MAX_LEN) begin
        sweep_row(ch);
        second_cnt = second_cnt + 1'b1;
      end else begin
        drop_seen = 1'b1;
      end
      if (last) begin
        res.len = (first_len != 0) ? lcs_row[first_len - 1'b1] : '0;
        res.ovf = drop_seen;
        expected_results.push_back(res);
        clear_pair_state();
      end
    end
  endfunction

  function automatic void queue_word(input logic sel, input logic [CHAR_W-1:0] ch,
                                     input logic last, input bit drain);
    cmd_word_t w;
    w.sel   = sel;
    w.ch    = ch;
    w.last  = last;
    w.drain = drain;
    w.gap   = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    pending_words.push_back(w);
  endfunction

  function automatic void new_alphabet();
    wide_chars = ($urandom_range(0, 3) == 0);
    foreach (alphabet[k]) alphabet[k] = CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    return wide_chars ? CHAR_W'($urandom_range(0, 255)) : alphabet[$urandom_range(0, 3)];
  endfunction

  // noisy pairs carry random last marks on the first string, ignored words
  // inside the second string, and sometimes lose the final mark
  function automatic void queue_pair(input int n_first, input int n_second,
                                     input bit noisy, input bit drain);
    bit keep_last;
    keep_last = !(noisy && $urandom_range(0, 7) == 0);
    for (int i = 0; i < n_first; i++)
      queue_word(SEL_FIRST, pick_char(),
                 noisy ? 1'($urandom_range(0, 1)) : 1'(i == n_first - 1), drain && i == 0);
    for (int i = 0; i < n_second; i++) begin
      if (noisy && i != 0 && $urandom_range(0, 4) == 0)
        queue_word(SEL_FIRST, pick_char(), 1'($urandom_range(0, 1)), 1'b0);
      queue_word(SEL_SECOND, pick_char(), 1'(keep_last && i == n_second - 1),
                 drain && n_first == 0 && i == 0);
    end
    stim_words += n_first + n_second;
    if (keep_last) pairs++;
  endfunction

  // driver: one word per handshake, inputs change on the falling edge
  always @(negedge clk) begin
    cmd_word_t w;
    if (rst || (start && !taken)) begin
      // hold the current word until it is taken
    end else if (idle_left != 0) begin
      start     <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (pending_words.size() == 0) begin
      start <= 1'b0;
    end else if (pending_words[0].gap != 0) begin
      start     <= 1'b0;
      idle_left <= pending_words[0].gap - 1;
      pending_words[0].gap = 0;
    end else if (pending_words[0].drain && expected_results.size() != 0) begin
      start <= 1'b0;
    end else begin
      w = pending_words.pop_front();
      string_select <= w.sel;
      char_code     <= w.ch;
      last_char     <= w.last;
      start         <= 1'b1;
    end
  end

  // monitor, predictor and watchdog on the rising edge
  always @(posedge clk) begin
    lcs_result_t exp_res;
    if (rst) begin
      taken       <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: lcs_length %0d overflowed %0d", lcs_length, overflowed);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (lcs_length !== exp_res.len) begin
            $error("lcs_length: expected %0d, actual %0d", exp_res.len, lcs_length);
            mismatches++;
          end
          if (overflowed !== exp_res.ovf) begin
            $error("overflowed: expected %0d, actual %0d", exp_res.ovf, overflowed);
            mismatches++;
          end
        end
      end
      if (start && !busy) track_word(string_select, char_code, last_char);
      taken <= start && !busy;
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n_first;
    int n_second;
    rst           = 1'b1;
    start         = 1'b0;
    string_select = 1'b0;
    char_code     = '0;
    last_char     = 1'b0;
    idle_left     = 0;
    mismatches    = 0;
    stim_words    = 0;
    pairs         = 0;
    gaps_on       = 1'b0;
    wide_chars    = 1'b0;
    clear_pair_state();

    // empty first string
    queue_word(SEL_SECOND, 8'h7A, 1'b1, 1'b0);
    // extreme bytes, last mark on a first-string word, ignored word mid-second
    queue_word(SEL_FIRST, 8'h00, 1'b1, 1'b0);
    queue_word(SEL_FIRST, 8'hFF, 1'b0, 1'b0);
    queue_word(SEL_FIRST, 8'h5A, 1'b1, 1'b0);
    queue_word(SEL_SECOND, 8'hFF, 1'b0, 1'b0);
    queue_word(SEL_SECOND, 8'hA5, 1'b0, 1'b0);
    queue_word(SEL_FIRST, 8'h00, 1'b0, 1'b0);
    queue_word(SEL_SECOND, 8'h5A, 1'b1, 1'b0);
    // identical strings
    alphabet = '{8'h61, 8'h62, 8'h63, 8'h61};
    for (int i = 0; i < 4; i++) queue_word(SEL_FIRST, alphabet[i], 1'(i == 3), 1'b0);
    for (int i = 0; i < 4; i++) queue_word(SEL_SECOND, alphabet[i], 1'(i == 3), 1'b0);
    // disjoint strings, with idling
    gaps_on = 1'b1;
    queue_word(SEL_FIRST, 8'h61, 1'b0, 1'b0);
    queue_word(SEL_FIRST, 8'h61, 1'b1, 1'b0);
    queue_word(SEL_SECOND, 8'h62, 1'b0, 1'b0);
    queue_word(SEL_SECOND, 8'h62, 1'b1, 1'b0);
    // single match, sent only after every result is in
    queue_word(SEL_FIRST, 8'h71, 1'b1, 1'b1);
    queue_word(SEL_SECOND, 8'h71, 1'b1, 1'b0);

    while (stim_words < STIM_WORDS || pairs < MIN_PAIRS) begin
      gaps_on = ($urandom_range(0, 2) != 0);
      new_alphabet();
      if ($urandom_range(0, 15) == 0) begin
        n_first  = $urandom_range(64, 160);
        n_second = $urandom_range(1, 4);
      end else begin
        n_first  = $urandom_range(0, 12);
        n_second = $urandom_range(1, 12);
      end
      queue_pair(n_first, n_second, $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
    end
    // no idling at the end of the run
    for (int i = pending_words.size() - TAIL_WORDS; i < pending_words.size(); i++)
      if (i >= 0) pending_words[i].gap = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (MAX_LEN + 8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
